@@ hdl/sdhs_pkg.sv @@
// Shared types, constants and helpers for the SCAN disk head scheduler.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sdhs_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CYL_W        = 16;
    localparam int DISK_W       = 17;
    localparam int TOTAL_W      = 17;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    typedef enum logic [1:0] {
        REG_START = 2'd0,
        REG_DISK  = 2'd1,
        REG_SWEEP = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [CYL_W-1:0] request_cylinder;
        logic             last_request;
    } req_word_t;

    typedef struct packed {
        logic [CYL_W-1:0]   visit_cylinder;
        logic               end_stop;
        logic [TOTAL_W-1:0] head_travel;
        logic               overflow;
        logic               last_visit;
    } result_word_t;

    // Geometry the back end needs while it walks the schedule.
    typedef struct packed {
        logic [CYL_W-1:0] last_cyl;
        logic [CYL_W-1:0] head_cyl;
        logic             sweep_up;
    } sched_cfg_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_P1,
        S_STOP,
        S_P2,
        S_FLUSH
    } sched_state_t;

    function automatic logic [CYL_W-1:0] clamp_cyl(input logic [CYL_W-1:0] cyl,
                                                   input logic [CYL_W-1:0] limit);
        return (cyl > limit) ? limit : cyl;
    endfunction

endpackage

`default_nettype wire

@@ hdl/scan_disk_head_scheduler.sv @@
// Top level of the SCAN disk head scheduler: configuration registers and the
// front end, queue and back end wiring. Depends on sdhs_pkg, sdhs_front, sdhs_back.
//
//   channel   dir   handshake                      word
//   in        in    in_valid / in_ready            req_word_t
//   out       out   out_valid / out_ready          result_word_t
//   config    in    psel penable pwrite pready     pwdata / prdata, paddr
//
// The front end takes one request word per cycle while its four-word queue has room.
// The sorter inserts one queued request per cycle into the sorted cell row while no schedule runs.
// After a word marked last, each sweep of a batch looks at every stored cell once,
// besides the setup step, the end stop and the final visit.
// Input stalls while a schedule runs once the queue is full; output stalls hold it.
// Reset clears the counts and flags at once; there is no clearing pass.
`default_nettype none

module scan_disk_head_scheduler (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire sdhs_pkg::req_word_t          in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output sdhs_pkg::result_word_t            out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sdhs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sdhs_pkg::DATA_W-1:0]  pwdata,
    output logic [sdhs_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import sdhs_pkg::*;

    logic [CYL_W-1:0]  start_reg;
    logic [DISK_W-1:0] disk_reg;
    logic              sweep_reg;
    logic              wr_en;
    logic [1:0]        reg_sel;
    logic [DISK_W-1:0] disk_m1;
    logic [CYL_W-1:0]  last_cyl;
    sched_cfg_t        cfg;
    logic              q_valid;
    logic              q_ready;
    req_word_t         q_data;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            disk_reg  <= DISK_W'(200);
            sweep_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_START: start_reg <= pwdata[CYL_W-1:0];
                REG_DISK:  disk_reg  <= pwdata[DISK_W-1:0];
                REG_SWEEP: sweep_reg <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_START: prdata = DATA_W'(start_reg);
            REG_DISK:  prdata = DATA_W'(disk_reg);
            REG_SWEEP: prdata = DATA_W'(sweep_reg);
            default:   prdata = '0;
        endcase
    end

    // A zero-size disk acts as one cylinder; anything from 65536 up ends at 65535.
    assign disk_m1  = disk_reg - DISK_W'(1);
    assign last_cyl = (disk_reg == '0) ? '0 :
                      disk_reg[DISK_W-1] ? {CYL_W{1'b1}} : disk_m1[CYL_W-1:0];

    assign cfg.last_cyl = last_cyl;
    assign cfg.head_cyl = clamp_cyl(start_reg, last_cyl);
    assign cfg.sweep_up = sweep_reg;

    sdhs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .last_cyl (last_cyl),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    sdhs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ hdl/sdhs_front.sv @@
// Front end: takes request words, clamps them to the disk and queues them.
// Depends on sdhs_pkg.
`default_nettype none

module sdhs_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sdhs_pkg::req_word_t in_data,
    input  wire logic [15:0]        last_cyl,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output sdhs_pkg::req_word_t     q_data
);
    import sdhs_pkg::*;

    req_word_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              push;
    logic              pop;
    req_word_t         push_word;

    assign in_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_data   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        push_word.request_cylinder = clamp_cyl(in_data.request_cylinder, last_cyl);
        push_word.last_request     = in_data.last_request;
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + QCNT_W'(1)))
        else $error("queue fill count missed a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

@@ hdl/sdhs_back.sv @@
// Back end: insertion sorter over a row of request cells and the SCAN sequencer
// that walks the sorted row and delivers one visit word per step. Depends on sdhs_pkg.
`default_nettype none

module sdhs_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire sdhs_pkg::req_word_t  q_data,
    input  wire sdhs_pkg::sched_cfg_t cfg,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sdhs_pkg::result_word_t    out_data
);
    import sdhs_pkg::*;

    logic [CYL_W-1:0]   cell_reg [MAX_REQUESTS];
    logic [CYL_W-1:0]   ins_cell [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] gt;

    sched_state_t       state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped_reg, dropped_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CYL_W-1:0]   cur_reg, cur_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    result_word_t       pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    result_word_t       out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               load_en;
    logic               has_room;
    logic [IDX_W-1:0]   last_idx;
    logic [CYL_W-1:0]   cur_c;
    logic [CYL_W-1:0]   vis_c;
    logic [CYL_W-1:0]   step_dist;
    logic [TOTAL_W-1:0] total_new;
    logic               first_pred;
    logic               emit_ok;
    logic               asc;
    logic               phase_end;
    logic               out_free;
    logic               adv;
    logic               emit;
    result_word_t       new_res;

    // Parallel insertion: every cell holding a larger value shifts up by one,
    // and the first such cell (or the first empty one) takes the new request.
    for (genvar i = 0; i < MAX_REQUESTS; i++)
    begin : g_cell
        logic take;
        assign gt[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] > q_data.request_cylinder);
        assign take  = gt[i] || (CNT_W'(i) == count_reg);
        if (i == 0)
        begin : g_first
            assign ins_cell[i] = take ? q_data.request_cylinder : cell_reg[i];
        end
        else
        begin : g_rest
            assign ins_cell[i] = take ? (gt[i-1] ? cell_reg[i-1] : q_data.request_cylinder)
                                      : cell_reg[i];
        end
    end

    assign has_room  = (count_reg < CNT_W'(MAX_REQUESTS));
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign cur_c     = cell_reg[idx_reg];
    assign first_pred = cfg.sweep_up ? (cur_c >= cfg.head_cyl) : (cur_c <= cfg.head_cyl);
    assign emit_ok   = (state_reg == S_P1) ? first_pred : !first_pred;
    assign asc       = (state_reg == S_P1) ? cfg.sweep_up : !cfg.sweep_up;
    assign phase_end = asc ? (idx_reg == last_idx) : (idx_reg == '0);
    assign vis_c     = (state_reg == S_STOP) ? (cfg.sweep_up ? cfg.last_cyl : '0) : cur_c;
    assign step_dist = (vis_c > cur_reg) ? (vis_c - cur_reg) : (cur_reg - vis_c);
    assign total_new = total_reg + TOTAL_W'(step_dist);
    assign out_free  = !out_valid_reg || out_ready;
    // A new visit may be produced once the held one can move to the output.
    assign adv       = !pend_valid_reg || out_free;

    always_comb
    begin
        new_res.visit_cylinder = vis_c;
        new_res.end_stop       = (state_reg == S_STOP);
        new_res.head_travel    = total_new;
        new_res.overflow       = dropped_reg;
        new_res.last_visit     = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        dropped_next    = dropped_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        total_next      = total_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        q_ready         = 1'b0;
        load_en         = 1'b0;
        emit            = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    if (has_room)
                    begin
                        load_en    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (q_data.last_request)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                cur_next   = cfg.head_cyl;
                total_next = '0;
                if (count_reg == '0)
                begin
                    state_next = S_STOP;
                end
                else
                begin
                    state_next = S_P1;
                    idx_next   = cfg.sweep_up ? '0 : last_idx;
                end
            end
            S_P1, S_P2:
            begin
                if (adv)
                begin
                    emit = emit_ok;
                    if (phase_end)
                    begin
                        state_next = (state_reg == S_P1) ? S_STOP : S_FLUSH;
                    end
                    else
                    begin
                        idx_next = asc ? idx_reg + IDX_W'(1) : idx_reg - IDX_W'(1);
                    end
                end
            end
            S_STOP:
            begin
                if (adv)
                begin
                    emit = 1'b1;
                    if (count_reg == '0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_P2;
                        idx_next   = cfg.sweep_up ? last_idx : '0;
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_next            = pend_reg;
                    out_next.last_visit = 1'b1;
                    out_valid_next      = 1'b1;
                    pend_valid_next     = 1'b0;
                    count_next          = '0;
                    dropped_next        = 1'b0;
                    state_next          = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // The newest visit is held back one step so the final one can be marked.
        if (emit)
        begin
            cur_next        = vis_c;
            total_next      = total_new;
            pend_next       = new_res;
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            dropped_reg    <= dropped_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            cell_reg <= ins_cell;
        end
        idx_reg   <= idx_next;
        cur_reg   <= cur_next;
        total_reg <= total_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REQUESTS))
        else $error("request count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> !q_ready)
        else $error("queue popped while a schedule is running");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && out_free) |=> (count_reg == '0 && !dropped_reg))
        else $error("batch state not cleared after the final visit");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg != S_LOAD && state_reg != S_START))
        else $error("held visit outside a schedule");

endmodule

`default_nettype wire

@@ dv/tb_scan_disk_head_scheduler.sv @@
// Self-checking testbench for the SCAN disk head scheduler: request words go in
// with bursty timing; every visit word is compared with an in-bench predictor or
// a hand-written visit. Depends on sdhs_pkg and scan_disk_head_scheduler.
`timescale 1ns / 100ps

module tb_scan_disk_head_scheduler;

    import sdhs_pkg::*;

    localparam int RANDOM_WORDS  = 150;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_LIMIT   = 40;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} stall_mode_t;

    typedef struct {
        row_kind_t    kind;
        reg_index_t   idx;
        logic [31:0]  value;
        req_word_t    word;
        bit           typed;
        result_word_t first_visit;
        result_word_t second_visit;
    } stim_row_t;

    localparam result_word_t NO_VISIT = '0;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    req_word_t           in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    result_word_t        out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Predictor copy of the registers and the sorted request store.
    logic [CYL_W-1:0]    cfg_start = '0;
    logic [DISK_W-1:0]   cfg_disk  = 17'd200;
    logic                cfg_sweep = 1'b1;
    logic [CYL_W-1:0]    sorted_cyl [MAX_REQUESTS];
    int                  stored_count = 0;
    logic                dropped_flag_q = 1'b0;

    result_word_t        visit_q [$];
    stim_row_t           rows [$];
    result_word_t        front_visit;

    int                  mismatches = 0;
    int                  visits_checked = 0;
    int                  words_sent = 0;
    int                  batches = 0;
    int                  settings_applied = 0;
    int                  burst_left = 0;
    int                  rx_cycle = 0;
    stall_mode_t         rx_mode = RX_OPEN;

    scan_disk_head_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 clk = ~clk;

    function automatic logic [CYL_W-1:0] last_cylinder();
        if (cfg_disk == '0)
            return '0;
        if (cfg_disk > 17'h10000)
            return '1;
        return cfg_disk[CYL_W-1:0] - 1'b1;
    endfunction

    // Moves the head to a new cylinder and builds the visit word for it.
    function automatic result_word_t move_head(input logic [CYL_W-1:0] to, input logic stop,
                                               inout logic [CYL_W-1:0] cur,
                                               inout logic [TOTAL_W-1:0] total);
        result_word_t r;
        total = total + ((to > cur) ? {1'b0, to - cur} : {1'b0, cur - to});
        cur = to;
        r.visit_cylinder = to;
        r.end_stop       = stop;
        r.head_travel    = total;
        r.overflow       = dropped_flag_q;
        r.last_visit     = 1'b0;
        return r;
    endfunction

    // Inserts one request into the sorted store; a word marked last yields the
    // whole elevator schedule and empties the store.
    function automatic void schedule_request(input req_word_t w, ref result_word_t batch[$]);
        logic [CYL_W-1:0]   lim;
        logic [CYL_W-1:0]   req;
        logic [CYL_W-1:0]   head;
        logic [CYL_W-1:0]   cur;
        logic [TOTAL_W-1:0] total;
        result_word_t       tail;
        int                 pos;
        lim = last_cylinder();
        req = (w.request_cylinder > lim) ? lim : w.request_cylinder;
        batch.delete();
        if (stored_count < MAX_REQUESTS) begin
            pos = stored_count;
            while (pos > 0 && sorted_cyl[pos-1] > req) begin
                sorted_cyl[pos] = sorted_cyl[pos-1];
                pos--;
            end
            sorted_cyl[pos] = req;
            stored_count++;
        end
        else begin
            dropped_flag_q = 1'b1;
        end
        if (!w.last_request)
            return;
        head  = (cfg_start > lim) ? lim : cfg_start;
        cur   = head;
        total = '0;
        if (cfg_sweep) begin
            for (int i = 0; i < stored_count; i++)
                if (sorted_cyl[i] >= head)
                    batch.push_back(move_head(sorted_cyl[i], 1'b0, cur, total));
            batch.push_back(move_head(lim, 1'b1, cur, total));
            for (int i = stored_count - 1; i >= 0; i--)
                if (sorted_cyl[i] < head)
                    batch.push_back(move_head(sorted_cyl[i], 1'b0, cur, total));
        end
        else begin
            for (int i = stored_count - 1; i >= 0; i--)
                if (sorted_cyl[i] <= head)
                    batch.push_back(move_head(sorted_cyl[i], 1'b0, cur, total));
            batch.push_back(move_head('0, 1'b1, cur, total));
            for (int i = 0; i < stored_count; i++)
                if (sorted_cyl[i] > head)
                    batch.push_back(move_head(sorted_cyl[i], 1'b0, cur, total));
        end
        tail = batch.pop_back();
        tail.last_visit = 1'b1;
        batch.push_back(tail);
        foreach (sorted_cyl[i])
            sorted_cyl[i] = '0;
        stored_count   = 0;
        dropped_flag_q = 1'b0;
    endfunction

    function automatic result_word_t visit_word(input logic [CYL_W-1:0] cyl, input logic stop,
                                                input logic [TOTAL_W-1:0] total,
                                                input logic last);
        result_word_t r;
        r.visit_cylinder = cyl;
        r.end_stop       = stop;
        r.head_travel    = total;
        r.overflow       = 1'b0;
        r.last_visit     = last;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input reg_index_t idx, input logic [31:0] value);
        stim_row_t r;
        r = '{ROW_CFG, idx, value, '0, 1'b0, NO_VISIT, NO_VISIT};
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic [CYL_W-1:0] cyl, input logic last);
        stim_row_t r;
        r = '{ROW_ITEM, REG_START, 32'd0, '0, 1'b0, NO_VISIT, NO_VISIT};
        r.word.request_cylinder = cyl;
        r.word.last_request     = last;
        return r;
    endfunction

    // A one-request batch whose two visits are written out by hand.
    function automatic stim_row_t typed_row(input logic [CYL_W-1:0] cyl,
                                            input result_word_t v0, input result_word_t v1);
        stim_row_t r;
        r = item_row(cyl, 1'b1);
        r.typed        = 1'b1;
        r.first_visit  = v0;
        r.second_visit = v1;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("visit %0d: %s is %0d, expected %0d",
                                      visits_checked, field, got, want));
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START: cfg_start = value[CYL_W-1:0];
            REG_DISK:  cfg_disk  = value[DISK_W-1:0];
            REG_SWEEP: cfg_sweep = value[0];
            default: ;
        endcase
    endtask

    // Offers one request word, with the sender idling between bursts, and
    // queues the visits it is expected to cause once it is accepted.
    task automatic push_request(input req_word_t w, input bit typed,
                                input result_word_t v0, input result_word_t v1);
        result_word_t batch [$];
        int           gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48)
                                                      : $urandom_range(1, 8);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        words_sent++;
        schedule_request(w, batch);
        if (typed) begin
            batch.delete();
            batch.push_back(v0);
            batch.push_back(v1);
        end
        foreach (batch[k])
            visit_q.push_back(batch[k]);
    endtask

    // Registers change only once the schedule has fully drained.
    task automatic drain_schedule();
        in_valid <= 1'b0;
        while (visit_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CYL_W-1:0] start, input logic [DISK_W-1:0] disk,
                                  input logic sweep);
        drain_schedule();
        write_reg(REG_START, {16'd0, start});
        write_reg(REG_DISK, {15'd0, disk});
        write_reg(REG_SWEEP, {31'd0, sweep});
        settings_applied++;
    endtask

    // Receiver stalls follow a mode drawn at random: open, coin toss, sparse or bursty.
    always @(posedge clk) begin
        if (rx_cycle % 48 == 0)
            rx_mode = stall_mode_t'($urandom_range(0, 3));
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= (rx_cycle % 16) < 3;
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (visit_q.size() == 0) begin
                report_mismatch($sformatf("unexpected visit word to cylinder %0d",
                                          out_data.visit_cylinder));
            end
            else begin
                front_visit = visit_q.pop_front();
                check_field("visit_cylinder", 32'(out_data.visit_cylinder),
                            32'(front_visit.visit_cylinder));
                check_field("end_stop", 32'(out_data.end_stop), 32'(front_visit.end_stop));
                check_field("head_travel", 32'(out_data.head_travel),
                            32'(front_visit.head_travel));
                check_field("overflow", 32'(out_data.overflow), 32'(front_visit.overflow));
                check_field("last_visit", 32'(out_data.last_visit),
                            32'(front_visit.last_visit));
            end
            visits_checked++;
        end
    end

    initial begin
        #4_000_000;
        $display("FAIL scan_disk_head_scheduler");
        $finish;
    end

    initial begin
        int                random_words;
        int                len;
        bit                overflow_done;
        logic [DISK_W-1:0] disk_pick;
        logic [CYL_W-1:0]  start_pick;
        logic [CYL_W-1:0]  lim;
        logic [CYL_W-1:0]  cyl;
        logic [CYL_W-1:0]  prev_cyl;
        req_word_t         w;

        random_words  = 0;
        overflow_done = 1'b0;
        prev_cyl      = '0;
        foreach (sorted_cyl[i])
            sorted_cyl[i] = '0;

        // Reset settings: start 0, 200 cylinders, sweeping up.
        rows.push_back(typed_row(16'd50, visit_word(16'd50, 1'b0, 17'd50, 1'b0),
                                 visit_word(16'd199, 1'b1, 17'd199, 1'b1)));
        rows.push_back(typed_row(16'd0, visit_word(16'd0, 1'b0, 17'd0, 1'b0),
                                 visit_word(16'd199, 1'b1, 17'd199, 1'b1)));
        // Request beyond the disk is clamped onto the end stop.
        rows.push_back(typed_row(16'hFFFF, visit_word(16'd199, 1'b0, 17'd199, 1'b0),
                                 visit_word(16'd199, 1'b1, 17'd199, 1'b1)));
        // Duplicates and a request equal to the start, in both directions.
        rows.push_back(cfg_row(REG_START, 32'd100));
        rows.push_back(cfg_row(REG_SWEEP, 32'd0));
        rows.push_back(item_row(16'd100, 1'b0));
        rows.push_back(item_row(16'd150, 1'b0));
        rows.push_back(item_row(16'd20, 1'b0));
        rows.push_back(item_row(16'd20, 1'b0));
        rows.push_back(item_row(16'd180, 1'b1));
        rows.push_back(cfg_row(REG_SWEEP, 32'd1));
        rows.push_back(item_row(16'd100, 1'b0));
        rows.push_back(item_row(16'd150, 1'b0));
        rows.push_back(item_row(16'd20, 1'b0));
        rows.push_back(item_row(16'd20, 1'b0));
        rows.push_back(item_row(16'd180, 1'b1));
        // Start beyond the disk is clamped to the last cylinder.
        rows.push_back(cfg_row(REG_START, 32'd65535));
        rows.push_back(typed_row(16'd10, visit_word(16'd199, 1'b1, 17'd0, 1'b0),
                                 visit_word(16'd10, 1'b0, 17'd189, 1'b1)));
        // A zero-size disk behaves as a single cylinder.
        rows.push_back(cfg_row(REG_DISK, 32'd0));
        rows.push_back(typed_row(16'hFFFF, visit_word(16'd0, 1'b0, 17'd0, 1'b0),
                                 visit_word(16'd0, 1'b1, 17'd0, 1'b1)));
        // An oversize disk behaves as 65536 cylinders.
        rows.push_back(cfg_row(REG_DISK, 32'd131071));
        rows.push_back(cfg_row(REG_START, 32'd0));
        rows.push_back(cfg_row(REG_SWEEP, 32'd0));
        rows.push_back(typed_row(16'hFFFF, visit_word(16'd0, 1'b1, 17'd0, 1'b0),
                                 visit_word(16'hFFFF, 1'b0, 17'd65535, 1'b1)));
        rows.push_back(cfg_row(REG_DISK, 32'd65536));
        rows.push_back(cfg_row(REG_START, 32'd65535));
        rows.push_back(item_row(16'd0, 1'b0));
        rows.push_back(item_row(16'hFFFF, 1'b1));
        // Largest head movement the disk allows.
        rows.push_back(cfg_row(REG_START, 32'd1));
        rows.push_back(cfg_row(REG_SWEEP, 32'd1));
        rows.push_back(typed_row(16'd0, visit_word(16'hFFFF, 1'b1, 17'd65534, 1'b0),
                                 visit_word(16'd0, 1'b0, 17'd131069, 1'b1)));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                drain_schedule();
                write_reg(rows[i].idx, rows[i].value);
                settings_applied++;
            end
            else begin
                push_request(rows[i].word, rows[i].typed, rows[i].first_visit,
                             rows[i].second_visit);
                if (rows[i].word.last_request)
                    batches++;
            end
        end

        // Random phases: new settings, then a few batches each ending in a last word.
        while (random_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 7))
                0:       disk_pick = 17'd0;
                1:       disk_pick = 17'd1;
                2:       disk_pick = 17'h10000;
                3:       disk_pick = DISK_W'($urandom_range(65537, 131071));
                4:       disk_pick = 17'd200;
                5:       disk_pick = DISK_W'($urandom_range(1, 65536));
                default: disk_pick = DISK_W'($urandom_range(2, 1000));
            endcase
            case ($urandom_range(0, 3))
                0:       start_pick = '0;
                1:       start_pick = '1;
                2:       start_pick = CYL_W'($urandom_range(0, 1000));
                default: start_pick = CYL_W'($urandom());
            endcase
            apply_settings(start_pick, disk_pick, 1'($urandom_range(0, 1)));
            lim = last_cylinder();
            repeat ($urandom_range(2, 4)) begin
                // The first batch overfills the store so later words are dropped.
                if (!overflow_done)
                    len = MAX_REQUESTS + 3;
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(MAX_REQUESTS - 2, MAX_REQUESTS + 4);
                else
                    len = $urandom_range(1, 8);
                overflow_done = 1'b1;
                for (int j = 0; j < len; j++) begin
                    case ($urandom_range(0, 6))
                        0, 1:    cyl = CYL_W'($urandom_range(0, lim));
                        2:       cyl = prev_cyl;
                        3:       cyl = CYL_W'($urandom());
                        4:       cyl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                        5:       cyl = cfg_start;
                        default: cyl = CYL_W'($urandom_range(0, lim));
                    endcase
                    prev_cyl = cyl;
                    w.request_cylinder = cyl;
                    w.last_request     = (j == len - 1);
                    push_request(w, 1'b0, NO_VISIT, NO_VISIT);
                    random_words++;
                end
                batches++;
            end
        end

        drain_schedule();

        $display("Covered %0d request words in %0d batches under %0d register writes or settings.",
                 words_sent, batches, settings_applied);
        $display("Compared %0d visit words; %0d mismatches.", visits_checked, mismatches);
        if (mismatches == 0)
            $display("PASS scan_disk_head_scheduler");
        else
            $display("FAIL scan_disk_head_scheduler");
        $finish;
    end

endmodule

@@ files.f @@
hdl/sdhs_pkg.sv
hdl/sdhs_front.sv
hdl/sdhs_back.sv
hdl/scan_disk_head_scheduler.sv
dv/tb_scan_disk_head_scheduler.sv
